// ===== rtl/tilt_pkg.sv =====
// shared types and constants for the tilt angle pipeline
`timescale 1ns / 1ps
package tilt_pkg;
  localparam int AXIS_W = 12;
  localparam int SQ_W = 24;
  localparam int ROOT_W = 20;
  localparam int CW = 24;
  localparam int ZW = 24;
  localparam int ATAN_LEN = 24;
  localparam int DEG_W = 8;

  typedef logic [ZW-1:0] atan_t;

  function automatic atan_t atan_deg_q16(input logic [4:0] i);
    case (i)
      5'd0: atan_deg_q16 = 24'd2949120;
      5'd1: atan_deg_q16 = 24'd1740967;
      5'd2: atan_deg_q16 = 24'd919879;
      5'd3: atan_deg_q16 = 24'd466945;
      5'd4: atan_deg_q16 = 24'd234379;
      5'd5: atan_deg_q16 = 24'd117304;
      5'd6: atan_deg_q16 = 24'd58666;
      5'd7: atan_deg_q16 = 24'd29335;
      5'd8: atan_deg_q16 = 24'd14668;
      5'd9: atan_deg_q16 = 24'd7334;
      5'd10: atan_deg_q16 = 24'd3667;
      5'd11: atan_deg_q16 = 24'd1833;
      5'd12: atan_deg_q16 = 24'd917;
      5'd13: atan_deg_q16 = 24'd458;
      5'd14: atan_deg_q16 = 24'd229;
      5'd15: atan_deg_q16 = 24'd115;
      5'd16: atan_deg_q16 = 24'd57;
      5'd17: atan_deg_q16 = 24'd29;
      5'd18: atan_deg_q16 = 24'd14;
      5'd19: atan_deg_q16 = 24'd7;
      5'd20: atan_deg_q16 = 24'd4;
      5'd21: atan_deg_q16 = 24'd2;
      5'd22: atan_deg_q16 = 24'd1;
      default: atan_deg_q16 = 24'd0;
    endcase
  endfunction

  typedef struct packed {
    logic [7:0] x_high_byte;
    logic [7:0] x_low_byte;
    logic [7:0] y_high_byte;
    logic [7:0] y_low_byte;
    logic [7:0] z_high_byte;
    logic [7:0] z_low_byte;
  } sample_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] x_accel;
    logic signed [AXIS_W-1:0] y_accel;
    logic signed [AXIS_W-1:0] z_accel;
    logic signed [DEG_W-1:0] roll_degrees;
    logic signed [DEG_W-1:0] pitch_degrees;
  } result_t;
endpackage

// ===== rtl/tilt_if.sv =====
// valid/ready channel interfaces for samples and results
`timescale 1ns / 1ps
interface tilt_sample_if;
  logic valid;
  logic ready;
  logic [7:0] x_high_byte;
  logic [7:0] x_low_byte;
  logic [7:0] y_high_byte;
  logic [7:0] y_low_byte;
  logic [7:0] z_high_byte;
  logic [7:0] z_low_byte;
  modport source(output valid, x_high_byte, x_low_byte, y_high_byte, y_low_byte,
    z_high_byte, z_low_byte, input ready);
  modport sink(input valid, x_high_byte, x_low_byte, y_high_byte, y_low_byte,
    z_high_byte, z_low_byte, output ready);
endinterface

interface tilt_result_if;
  logic valid;
  logic ready;
  logic signed [11:0] x_accel;
  logic signed [11:0] y_accel;
  logic signed [11:0] z_accel;
  logic signed [7:0] roll_degrees;
  logic signed [7:0] pitch_degrees;
  modport source(output valid, x_accel, y_accel, z_accel, roll_degrees, pitch_degrees,
    input ready);
  modport sink(input valid, x_accel, y_accel, z_accel, roll_degrees, pitch_degrees,
    output ready);
endinterface

// ===== rtl/tilt_sqrt.sv =====
// pipelined restoring square root, one result bit per stage
`timescale 1ns / 1ps
module tilt_sqrt (
  input  logic clk,
  input  logic en,
  input  logic [tilt_pkg::SQ_W-1:0] sq,
  output logic [tilt_pkg::ROOT_W-1:0] root
);
  import tilt_pkg::*;
  // radicand is sq << 16, 40 bits, root fits in 20 bits
  localparam int RW = 2 * ROOT_W;
  localparam int REMW = ROOT_W + 2;

  logic [RW-1:0] rad [ROOT_W+1];
  logic [REMW-1:0] rem [ROOT_W+1];
  logic [ROOT_W-1:0] res [ROOT_W+1];

  always_comb begin
    rad[0] = {sq, 16'd0};
    rem[0] = '0;
    res[0] = '0;
  end

  for (genvar s = 0; s < ROOT_W; s++) begin : g_step
    logic [REMW-1:0] trial;
    logic [REMW-1:0] cur;
    logic [REMW-1:0] sub;
    always_comb begin
      cur = {rem[s][REMW-3:0], rad[s][RW-1 -: 2]};
      sub = {res[s], 2'b01};
      trial = cur - sub;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rad[s+1] <= {rad[s][RW-3:0], 2'b00};
        if (cur >= sub) begin
          rem[s+1] <= trial;
          res[s+1] <= {res[s][ROOT_W-2:0], 1'b1};
        end else begin
          rem[s+1] <= cur;
          res[s+1] <= {res[s][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = res[ROOT_W];
endmodule

// ===== rtl/tilt_cordic.sv =====
// pipelined vectoring cordic giving the angle in degrees
`timescale 1ns / 1ps
module tilt_cordic #(
  parameter int STAGES = 16
) (
  input  logic clk,
  input  logic en,
  input  logic [tilt_pkg::ROOT_W-1:0] mag,
  input  logic signed [tilt_pkg::AXIS_W:0] num,
  input  logic zero_div,
  output logic signed [tilt_pkg::DEG_W-1:0] deg
);
  import tilt_pkg::*;
  localparam int N = (STAGES < ATAN_LEN) ? STAGES : ATAN_LEN;

  logic signed [CW-1:0] xs [N+1];
  logic signed [CW-1:0] ys [N+1];
  logic signed [ZW-1:0] zs [N+1];
  logic zd [N+1];
  logic signed [AXIS_W:0] ns [N+1];

  always_comb begin
    xs[0] = CW'($signed({1'b0, mag}));
    ys[0] = CW'($signed({num, 8'd0}));
    zs[0] = '0;
    zd[0] = zero_div;
    ns[0] = num;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] t;
    always_comb begin
      dx = xs[i] >>> i;
      dy = ys[i] >>> i;
      t = $signed(atan_deg_q16(5'(i)));
    end
    always_ff @(posedge clk) begin
      if (en) begin
        zd[i+1] <= zd[i];
        ns[i+1] <= ns[i];
        if (!ys[i][CW-1]) begin
          xs[i+1] <= xs[i] + dy;
          ys[i+1] <= ys[i] - dx;
          zs[i+1] <= zs[i] + t;
        end else begin
          xs[i+1] <= xs[i] - dy;
          ys[i+1] <= ys[i] + dx;
          zs[i+1] <= zs[i] - t;
        end
      end
    end
  end

  logic signed [ZW-1:0] zf;
  logic [ZW-1:0] zmag;
  logic [ZW-17:0] whole;
  always_comb begin
    zf = zs[N];
    zmag = zf[ZW-1] ? ZW'(-zf) : zf;
    whole = (zmag[ZW-1:16] > (ZW-16)'(90)) ? (ZW-16)'(90) : zmag[ZW-1:16];
    if (zd[N]) begin
      if (ns[N] == '0) deg = '0;
      else if (ns[N][AXIS_W]) deg = -8'sd90;
      else deg = 8'sd90;
    end else if (zf[ZW-1]) begin
      deg = DEG_W'(-$signed({1'b0, whole}));
    end else begin
      deg = DEG_W'(whole);
    end
  end
endmodule

// ===== rtl/accel_tilt_angles_core.sv =====
// top level: accelerometer sample to axis values and roll/pitch angles
// usage:
//   samples arrive on a valid/ready channel as six raw register bytes; each
//   result leaves on a valid/ready channel with the three 12-bit axis values
//   and roll and pitch in whole degrees truncated toward zero.
//   the pipeline takes one sample per cycle while the output is not stalled. it has
//   an axis/square stage, one square-root stage per result bit and one stage per
//   cordic rotation, with 16 cordic stages by default.
//   a stall at the output freezes the whole pipeline; the input ready then
//   drops, and no item is lost or repeated. empty slots stay in place while
//   the output is stalled; the pipeline only advances when the last stage
//   is empty or its item is taken.
//   synchronous reset clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
module accel_tilt_angles_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst,
  tilt_sample_if.sink sample,
  tilt_result_if.source result
);
  import tilt_pkg::*;
  localparam int NC = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
  localparam int LAT = 1 + ROOT_W + NC;

  logic [LAT-1:0] vld;
  logic en;
  assign en = result.ready || !vld[LAT-1];
  assign sample.ready = en;

  logic signed [AXIS_W-1:0] xa, ya, za;
  assign xa = $signed({sample.x_high_byte, sample.x_low_byte[7:4]});
  assign ya = $signed({sample.y_high_byte, sample.y_low_byte[7:4]});
  assign za = $signed({sample.z_high_byte, sample.z_low_byte[7:4]});

  // stage 1: sums of squares
  logic [SQ_W-1:0] sq_r, sq_p;
  logic signed [AXIS_W-1:0] xr, yr, zr;
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= SQ_W'(ya * ya) + SQ_W'(za * za);
      sq_p <= SQ_W'(xa * xa) + SQ_W'(za * za);
      xr <= xa;
      yr <= ya;
      zr <= za;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], sample.valid};
  end

  logic [ROOT_W-1:0] root_r, root_p;
  tilt_sqrt u_sqrt_r (.clk(clk), .en(en), .sq(sq_p), .root(root_r));
  tilt_sqrt u_sqrt_p (.clk(clk), .en(en), .sq(sq_r), .root(root_p));

  // carry axes and divisor-zero flags alongside the square root
  logic signed [AXIS_W-1:0] xd [ROOT_W+1];
  logic signed [AXIS_W-1:0] yd [ROOT_W+1];
  logic signed [AXIS_W-1:0] zdl [ROOT_W+1];
  logic zr_d [ROOT_W+1];
  logic zp_d [ROOT_W+1];
  always_comb begin
    xd[0] = xr;
    yd[0] = yr;
    zdl[0] = zr;
    zr_d[0] = (sq_p == '0);
    zp_d[0] = (sq_r == '0);
  end
  for (genvar s = 0; s < ROOT_W; s++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        xd[s+1] <= xd[s];
        yd[s+1] <= yd[s];
        zdl[s+1] <= zdl[s];
        zr_d[s+1] <= zr_d[s];
        zp_d[s+1] <= zp_d[s];
      end
    end
  end

  logic signed [AXIS_W:0] num_r, num_p;
  assign num_r = (AXIS_W+1)'(yd[ROOT_W]);
  assign num_p = -(AXIS_W+1)'(xd[ROOT_W]);

  logic signed [DEG_W-1:0] roll, pitch;
  tilt_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_r (
    .clk(clk), .en(en), .mag(root_r), .num(num_r), .zero_div(zr_d[ROOT_W]), .deg(roll));
  tilt_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_p (
    .clk(clk), .en(en), .mag(root_p), .num(num_p), .zero_div(zp_d[ROOT_W]), .deg(pitch));

  logic signed [AXIS_W-1:0] xo [NC+1];
  logic signed [AXIS_W-1:0] yo [NC+1];
  logic signed [AXIS_W-1:0] zo [NC+1];
  always_comb begin
    xo[0] = xd[ROOT_W];
    yo[0] = yd[ROOT_W];
    zo[0] = zdl[ROOT_W];
  end
  for (genvar c = 0; c < NC; c++) begin : g_out
    always_ff @(posedge clk) begin
      if (en) begin
        xo[c+1] <= xo[c];
        yo[c+1] <= yo[c];
        zo[c+1] <= zo[c];
      end
    end
  end

  assign result.valid = vld[LAT-1];
  assign result.x_accel = xo[NC];
  assign result.y_accel = yo[NC];
  assign result.z_accel = zo[NC];
  assign result.roll_degrees = roll;
  assign result.pitch_degrees = pitch;
endmodule
